// ===== sv/utf8vc_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8vc_pkg
// Types and helpers shared by the UTF-8 stream validate/count block.
// ----------------------------------------------------------------------------
package utf8vc_pkg;

  localparam logic [7:0] LEAD_MASK = 8'hF8;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC0;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // one input word
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } utf8vc_in_t;

  // one result word
  typedef struct packed {
    logic        char_done;
    logic [31:0] char_word;
    logic [2:0]  char_length;
    logic        string_end;
    logic        string_ok;
    logic [15:0] char_total;
  } utf8vc_out_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic [2:0] lead_len;   // 0: not a valid lead byte
    logic       is_cont;    // matches 10xxxxxx
  } utf8vc_cls_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [7:0] top;
    top = b & LEAD_MASK;
    if (top <= ASCII_MAX) begin
      lead_length = 3'd1;
    end else if (top >= LEAD2_LO && top < LEAD3_LO) begin
      lead_length = 3'd2;
    end else if (top >= LEAD3_LO && top < LEAD4_LO) begin
      lead_length = 3'd3;
    end else if (top >= LEAD4_LO && top < LEAD_MASK) begin
      lead_length = 3'd4;
    end else begin
      lead_length = 3'd0;
    end
  endfunction

endpackage

// ===== sv/utf8vc_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8vc_fifo
// Small register queue with count-based full/empty flags.
// ----------------------------------------------------------------------------
module utf8vc_fifo #(
  parameter int  DEPTH = 2,
  parameter type item_t = logic [7:0]
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fifo count above depth");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("fifo push did not add a word");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> count_r == $past(count_r) - CW'(1))
    else $error("fifo pop did not remove a word");
`endif

endmodule

// ===== sv/utf8vc_front.sv =====
// ----------------------------------------------------------------------------
// utf8vc_front
// Accepts input words and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module utf8vc_front
  import utf8vc_pkg::*;
(
  input  logic        in_push,
  input  utf8vc_in_t  in_data,
  output logic        in_full,
  input  logic        q_full,
  output logic        q_push,
  output utf8vc_cls_t q_data
);

  assign in_full = q_full;
  assign q_push  = in_push;

  always_comb begin
    q_data.byte_val = in_data.byte_in;
    q_data.last     = in_data.last_byte;
    q_data.lead_len = lead_length(in_data.byte_in);
    q_data.is_cont  = ((in_data.byte_in & CONT_MASK) == CONT_TAG);
  end

endmodule

// ===== sv/utf8vc_back.sv =====
// ----------------------------------------------------------------------------
// utf8vc_back
// Tracks the character in progress, error flag and count; builds results.
// ----------------------------------------------------------------------------
module utf8vc_back
  import utf8vc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  utf8vc_cls_t q_data,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        r_full,
  output logic        r_push,
  output utf8vc_out_t r_data
);

  logic [1:0]             bytes_left_r, bytes_left_step, bytes_left_nxt;
  logic [2:0]             char_size_r, char_size_step, char_size_nxt;
  logic [31:0]            partial_r, partial_step, partial_nxt;
  logic [1:0]             byte_pos_r, byte_pos_step, byte_pos_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_step, count_nxt;
  logic                   err_r, err_step, err_nxt;
  logic                   proc;
  logic                   done;
  logic [31:0]            word;
  logic [2:0]             len;
  logic [31:0]            lane;
  logic [31:0]            cnt_ext;

  assign proc   = !q_empty && !r_full;
  assign q_pop  = proc;
  assign r_push = proc;

  // place the continuation byte in its lane
  always_comb begin
    lane = '0;
    unique case (byte_pos_r)
      2'd0: lane[7:0]   = q_data.byte_val;
      2'd1: lane[15:8]  = q_data.byte_val;
      2'd2: lane[23:16] = q_data.byte_val;
      2'd3: lane[31:24] = q_data.byte_val;
    endcase
  end

  always_comb begin
    bytes_left_step = bytes_left_r;
    char_size_step  = char_size_r;
    partial_step    = partial_r;
    byte_pos_step   = byte_pos_r;
    count_step      = count_r;
    err_step        = err_r;
    done            = 1'b0;
    word            = '0;
    len             = '0;
    if (!err_r) begin
      if (bytes_left_r == 2'd0) begin
        if (q_data.lead_len == 3'd0) begin
          err_step = 1'b1;
        end else if (q_data.lead_len == 3'd1) begin
          done = 1'b1;
          word = {24'b0, q_data.byte_val};
          len  = 3'd1;
          if (count_r != '1) count_step = count_r + COUNT_WIDTH'(1);
        end else begin
          partial_step    = {24'b0, q_data.byte_val};
          char_size_step  = q_data.lead_len;
          bytes_left_step = 2'(q_data.lead_len - 3'd1);
          byte_pos_step   = 2'd1;
        end
      end else if (!q_data.is_cont) begin
        err_step = 1'b1;
      end else begin
        partial_step    = partial_r | lane;
        byte_pos_step   = byte_pos_r + 2'd1;
        bytes_left_step = bytes_left_r - 2'd1;
        if (bytes_left_step == 2'd0) begin
          done = 1'b1;
          word = partial_step;
          len  = char_size_r;
          if (count_r != '1) count_step = count_r + COUNT_WIDTH'(1);
        end
      end
      // character cut short by end of string
      if (q_data.last && bytes_left_step != 2'd0) err_step = 1'b1;
    end
  end

  assign cnt_ext = 32'(count_step);

  always_comb begin
    r_data.char_done   = done;
    r_data.char_word   = word;
    r_data.char_length = len;
    r_data.string_end  = q_data.last;
    r_data.string_ok   = !err_step;
    r_data.char_total  = cnt_ext[15:0];
  end

  // re-arm after the last byte
  always_comb begin
    if (q_data.last) begin
      bytes_left_nxt = '0;
      char_size_nxt  = '0;
      partial_nxt    = '0;
      byte_pos_nxt   = '0;
      count_nxt      = '0;
      err_nxt        = 1'b0;
    end else begin
      bytes_left_nxt = bytes_left_step;
      char_size_nxt  = char_size_step;
      partial_nxt    = partial_step;
      byte_pos_nxt   = byte_pos_step;
      count_nxt      = count_step;
      err_nxt        = err_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      char_size_r  <= '0;
      partial_r    <= '0;
      byte_pos_r   <= '0;
      count_r      <= '0;
      err_r        <= 1'b0;
    end else if (proc) begin
      bytes_left_r <= bytes_left_nxt;
      char_size_r  <= char_size_nxt;
      partial_r    <= partial_nxt;
      byte_pos_r   <= byte_pos_nxt;
      count_r      <= count_nxt;
      err_r        <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_len_matches_done: assert property (@(posedge clk) disable iff (!rst_n)
    r_push |-> (r_data.char_done == (r_data.char_length != 3'd0)))
    else $error("char_length and char_done disagree");
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && q_data.last) |=> (bytes_left_r == 2'd0 && count_r == '0 && !err_r))
    else $error("state not cleared after last byte");
  a_count_holds_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && err_r && !q_data.last) |=> (count_r == $past(count_r) && err_r))
    else $error("count moved after an error");
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (r_push && r_data.char_done) |-> !err_r)
    else $error("character completed after an error");
`endif

endmodule

// ===== sv/utf8_stream_validate_count_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validate_count_top
// UTF-8 byte stream validator and character counter.
//
//   channel  direction  handshake          payload
//   in_      input      in_push / in_full   utf8vc_in_t  (byte_in, last_byte)
//   out_     output     out_empty / out_pop utf8vc_out_t (one result per byte)
//
// One byte per cycle sustained while out_pop keeps up; each result is registered
// in the result queue after its byte is taken from the front queue.
// The rate is set by the back end's state update, done once per byte.
// Reset (rst_n low, synchronous) empties both queues and clears all state.
// A stalled out_pop fills the result queue, then the front queue, then raises
// in_full; each side stalls on its own.
// ----------------------------------------------------------------------------
module utf8_stream_validate_count_top
  import utf8vc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  utf8vc_in_t  in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output utf8vc_out_t out_data
);

  localparam int QDEPTH = 2;

  logic        cq_push, cq_full, cq_pop, cq_empty;
  utf8vc_cls_t cq_wr, cq_rd;
  logic        rq_push, rq_full;
  utf8vc_out_t rq_wr;

  utf8vc_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (cq_full),
    .q_push  (cq_push),
    .q_data  (cq_wr)
  );

  utf8vc_fifo #(
    .DEPTH  (QDEPTH),
    .item_t (utf8vc_cls_t)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .wr_data (cq_wr),
    .full    (cq_full),
    .pop     (cq_pop),
    .rd_data (cq_rd),
    .empty   (cq_empty)
  );

  utf8vc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (cq_rd),
    .q_empty (cq_empty),
    .q_pop   (cq_pop),
    .r_full  (rq_full),
    .r_push  (rq_push),
    .r_data  (rq_wr)
  );

  utf8vc_fifo #(
    .DEPTH  (QDEPTH),
    .item_t (utf8vc_out_t)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_wr),
    .full    (rq_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

// ===== tb/sv/utf8_stream_validate_count_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_validate_count_top_test
// Self-checking bench for the UTF-8 stream validator and character counter.
// Bytes are pushed as strings: directed edge cases first, then random strings
// that are mostly well-formed UTF-8 with some corrupted, truncated and noise
// strings mixed in.
// A local decoder predicts each result word, and the checker compares every
// popped word field by field. Both sides idle at random, except in the
// back-to-back part.
// ----------------------------------------------------------------------------
module utf8_stream_validate_count_top_test
  import utf8vc_pkg::*;
;

  localparam int CNT_W       = 16;
  localparam int IDLE_PCT    = 35;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 40;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  utf8vc_in_t  in_data;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  utf8vc_out_t out_data;

  utf8_stream_validate_count_top #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // decoder state mirrored from the block
  logic [1:0]       cont_left;
  logic [2:0]       char_len;
  logic [31:0]      char_acc;
  logic [1:0]       cont_pos;
  logic [CNT_W-1:0] char_cnt;
  logic             bad_seen;

  utf8vc_out_t decoded_q[$];
  logic [7:0]  str_q[$];

  bit idle_en   = 1'b1;
  int fail_cnt  = 0;
  int stall_cnt = 0;
  int n_bytes   = 0;
  int n_strings = 0;
  int n_chars   = 0;
  int n_invalid = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [2:0] char_size_of(logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic void clear_decoder();
    cont_left = '0;
    char_len  = '0;
    char_acc  = '0;
    cont_pos  = '0;
    char_cnt  = '0;
    bad_seen  = 1'b0;
  endfunction

  function automatic utf8vc_out_t decode_byte(utf8vc_in_t w);
    utf8vc_out_t r;
    logic [2:0]  n;
    r = '0;
    if (!bad_seen) begin
      if (cont_left == 2'd0) begin
        n = char_size_of(w.byte_in);
        if (n == 3'd0) begin
          bad_seen = 1'b1;
        end else if (n == 3'd1) begin
          r.char_done   = 1'b1;
          r.char_word   = {24'd0, w.byte_in};
          r.char_length = 3'd1;
          if (char_cnt != '1) char_cnt++;
        end else begin
          char_acc  = {24'd0, w.byte_in};
          char_len  = n;
          cont_left = 2'(n - 3'd1);
          cont_pos  = 2'd1;
        end
      end else if (w.byte_in[7:6] != 2'b10) begin
        bad_seen = 1'b1;
      end else begin
        char_acc  = char_acc | (32'(w.byte_in) << (8 * cont_pos));
        cont_pos  = cont_pos + 2'd1;
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          r.char_done   = 1'b1;
          r.char_word   = char_acc;
          r.char_length = char_len;
          if (char_cnt != '1) char_cnt++;
        end
      end
      // a character still open at the end of the string is an error
      if (w.last_byte && cont_left != 2'd0) bad_seen = 1'b1;
    end
    r.string_end = w.last_byte;
    r.string_ok  = !bad_seen;
    r.char_total = 16'(char_cnt);
    if (w.last_byte) clear_decoder();
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    utf8vc_in_t w;
    w.byte_in   = b;
    w.last_byte = last;
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= w;
    @(posedge clk);
    // hold the word until the block takes it
    while (in_full) @(posedge clk);
    decoded_q.push_back(decode_byte(w));
    n_bytes++;
  endtask

  task automatic send_str_q();
    foreach (str_q[i]) push_byte(str_q[i], i == str_q.size() - 1);
  endtask

  function automatic void add_char(int len);
    case (len)
      1:       str_q.push_back({1'b0, 7'($urandom)});
      2:       str_q.push_back({3'b110, 5'($urandom)});
      3:       str_q.push_back({4'b1110, 4'($urandom)});
      default: str_q.push_back({5'b11110, 3'($urandom)});
    endcase
    for (int i = 1; i < len; i++) str_q.push_back({2'b10, 6'($urandom)});
  endfunction

  task automatic send_random_strings(input int n_target);
    int start;
    int mode;
    start = n_bytes;
    while (n_bytes - start < n_target) begin
      str_q.delete();
      repeat ($urandom_range(1, 10)) add_char($urandom_range(1, 4));
      mode = $urandom_range(0, 99);
      if (mode >= 78 && mode < 86) begin
        // corrupt one byte
        str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom);
      end else if (mode >= 86 && mode < 92) begin
        // cut the tail off, usually mid-character
        repeat ($urandom_range(1, 3)) if (str_q.size() > 1) void'(str_q.pop_back());
      end else if (mode >= 92 && mode < 96) begin
        str_q.insert($urandom_range(0, str_q.size() - 1), {2'b10, 6'($urandom)});
      end else if (mode >= 96) begin
        str_q.delete();
        repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom));
      end
      send_str_q();
    end
  endtask

  task automatic test_directed_cases();
    // ASCII extremes
    str_q = '{8'h00, 8'h7F, 8'h41};
    send_str_q();
    // two- and three-byte characters
    str_q = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC};
    send_str_q();
    // largest four- and three-byte leads with all-ones payload
    str_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
    send_str_q();
    // stray continuation, then bytes after the error are dropped
    str_q = '{8'h80, 8'h41};
    send_str_q();
    str_q = '{8'hF8};
    send_str_q();
    str_q = '{8'hFF, 8'hC3, 8'hA9};
    send_str_q();
    // bad continuation byte
    str_q = '{8'hC3, 8'h41};
    send_str_q();
    // character cut short by the end of the string
    str_q = '{8'hE2, 8'h82};
    send_str_q();
    str_q = '{8'hC3};
    send_str_q();
  endtask

  task automatic test_random_strings();
    send_random_strings(600);
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_random_strings(150);
    idle_en = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    end
  endtask

  initial begin : result_check
    utf8vc_out_t want;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          $error("result word 0x%0h with none expected", out_data);
        end else begin
          want = decoded_q.pop_front();
          check_field("char_done",   32'(want.char_done),   32'(out_data.char_done));
          check_field("char_word",   want.char_word,        out_data.char_word);
          check_field("char_length", 32'(want.char_length), 32'(out_data.char_length));
          check_field("string_end",  32'(want.string_end),  32'(out_data.string_end));
          check_field("string_ok",   32'(want.string_ok),   32'(out_data.string_ok));
          check_field("char_total",  32'(want.char_total),  32'(out_data.char_total));
          if (want.char_done) n_chars++;
          if (want.string_end) n_strings++;
          if (want.string_end && !want.string_ok) n_invalid++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cnt >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    clear_decoder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_strings();
    test_back_to_back();

    @(negedge clk);
    in_push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes in %0d strings, %0d characters decoded,", n_bytes,
             n_strings, n_chars);
    $display("%0d strings flagged invalid.", n_invalid);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== utf8_stream_validate_count_top.f =====
sv/utf8vc_pkg.sv
sv/utf8vc_fifo.sv
sv/utf8vc_front.sv
sv/utf8vc_back.sv
sv/utf8_stream_validate_count_top.sv
tb/sv/utf8_stream_validate_count_top_test.sv
